FILE: sv/stc_pkg.sv
// Shared constants, types and the decimal power table for the scrolling text console writer.
package stc_pkg;

	localparam int PANE_ROWS   = 8;
	localparam int ROW_CELLS   = 32;
	localparam int COL_W       = 5;
	localparam int ROW_W       = (PANE_ROWS > 1) ? $clog2(PANE_ROWS) : 1;
	localparam int PANE_CELLS  = PANE_ROWS * ROW_CELLS;
	localparam int ADDR_W      = ROW_W + COL_W;
	localparam int BOTTOM_BASE = PANE_CELLS - ROW_CELLS;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_CURSOR  = 8'hFF;
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_ZERO    = 8'd48;

	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_RAW  = 2'd1;
	localparam logic [1:0] FUNC_DEC  = 2'd2;
	localparam logic [1:0] FUNC_READ = 2'd3;

	localparam logic [2:0] DIG_LAST = 3'd4;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [ROW_W:0]    rowx_t;
	typedef logic [COL_W-1:0]  col_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic        start;
		logic        take;
		logic [15:0] value;
	} dig_cmd_t;

	typedef struct packed {
		logic       ready;
		logic [3:0] digit;
		logic       last;
	} dig_out_t;

	function automatic logic [13:0] dec_pow(input logic [2:0] idx);
		logic [13:0] p;
		unique case (idx)
			3'd0:    p = 14'd10000;
			3'd1:    p = 14'd1000;
			3'd2:    p = 14'd100;
			3'd3:    p = 14'd10;
			default: p = 14'd1;
		endcase
		return p;
	endfunction

endpackage

FILE: sv/stc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module stc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/stc_digit_unit.sv
// Iterative decimal digit extractor: repeated subtraction of powers of ten, MSD first.
module stc_digit_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  stc_pkg::dig_cmd_t cmd,
	output stc_pkg::dig_out_t dout
);

	typedef enum logic [1:0] {
		D_IDLE,
		D_RUN,
		D_HOLD
	} dstate_t;

	dstate_t     state_q;
	logic [15:0] rem_q;
	logic [2:0]  pidx_q;
	logic [3:0]  cnt_q;
	logic        lead_q;
	logic [15:0] pow;

	assign pow = 16'(stc_pkg::dec_pow(pidx_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			rem_q   <= '0;
			pidx_q  <= '0;
			cnt_q   <= '0;
			lead_q  <= 1'b0;
		end else begin
			unique case (state_q)
				D_IDLE: begin
					if (cmd.start) begin
						rem_q   <= cmd.value;
						pidx_q  <= '0;
						cnt_q   <= '0;
						lead_q  <= 1'b0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (rem_q >= pow) begin
						rem_q <= rem_q - pow;
						cnt_q <= cnt_q + 4'd1;
					end else if (cnt_q != '0 || lead_q || pidx_q == stc_pkg::DIG_LAST) begin
						state_q <= D_HOLD;
					end else begin
						pidx_q <= pidx_q + 3'd1;
					end
				end
				D_HOLD: begin
					if (cmd.take) begin
						lead_q <= 1'b1;
						cnt_q  <= '0;
						if (pidx_q == stc_pkg::DIG_LAST) begin
							state_q <= D_IDLE;
						end else begin
							pidx_q  <= pidx_q + 3'd1;
							state_q <= D_RUN;
						end
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign dout.ready = (state_q == D_HOLD);
	assign dout.digit = cnt_q;
	assign dout.last  = (pidx_q == stc_pkg::DIG_LAST);

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout.ready |-> dout.digit <= 4'd9)
		else $error("digit out of range");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(dout.ready && !cmd.take) |=> (dout.ready && $stable(dout.digit)))
		else $error("digit dropped before take");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && state_q != D_IDLE) |-> 1'b0)
		else $error("start while busy");

endmodule

FILE: sv/scrolling_text_console_writer.sv
// Top level: text pane sequencer over a row-rotated pane RAM.
//
// channel  direction  handshake            payload
// in       to block   in_valid / in_stall  func, value, cell_index
// out      from block out_valid/out_stall  read_data, cursor_col
//
// After reset the pane RAM is initialized, one cell a cycle, over all PANE_CELLS cells
// (256 with 8 rows); in_stall is high throughout.
// Read: S_READ, control char: S_BLANK, raw or printable: S_STORE, S_MARK; then S_DONE.
// Passing column 31 rotates the row base and rewrites one row (S_SCROLL) in place of the
// cursor mark step.
// Newline: up to 32 padding writes plus the row rewrite.
// Decimal: per digit repeated subtraction plus the store; at most 5 digits.
// in_stall is low only when no item is in work; a result waits in the output register
// under out_stall while the next item is already taken.
module scrolling_text_console_writer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] value,
	input  logic [7:0]  cell_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic [4:0]  cursor_col
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_BLANK,
		S_STORE,
		S_MARK,
		S_NL,
		S_SCROLL,
		S_DWAIT,
		S_DONE
	} state_t;

	state_t            state_q;
	stc_pkg::col_t     col_q;
	stc_pkg::row_t     top_q;
	stc_pkg::addr_t    clr_q;
	logic [7:0]        byte_q;
	logic              dec_q;
	logic              last_q;
	logic              rd_ok_q;
	logic [7:0]        res_q;
	logic              out_valid_q;
	logic [7:0]        read_data_q;
	logic [4:0]        cursor_col_q;

	logic              accept;
	logic [7:0]        ch;
	logic [7:0]        mapped;
	logic              in_range;
	stc_pkg::row_t     bot_row;
	stc_pkg::row_t     lrow;
	stc_pkg::rowx_t    rsum;
	stc_pkg::row_t     rrow;
	stc_pkg::row_t     top_next;
	logic              wr_en;
	stc_pkg::addr_t    wr_addr;
	logic [7:0]        wr_data;
	stc_pkg::addr_t    rd_addr;
	logic [7:0]        rd_data;
	stc_pkg::dig_cmd_t dig_cmd;
	stc_pkg::dig_out_t dig_out;
	logic              out_free;
	state_t            after_step;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign ch = value[7:0];
	always_comb begin
		if (ch < 8'd96) begin
			mapped = ch & 8'd63;
		end else if (ch < 8'd128) begin
			mapped = ch - 8'd96;
		end else begin
			mapped = ch;
		end
	end

	assign bot_row  = (top_q == '0) ? stc_pkg::row_t'(stc_pkg::PANE_ROWS - 1)
	                                : top_q - stc_pkg::row_t'(1);
	assign top_next = (top_q == stc_pkg::row_t'(stc_pkg::PANE_ROWS - 1)) ? '0
	                                : top_q + stc_pkg::row_t'(1);

	assign in_range = (32'(cell_index) < stc_pkg::PANE_CELLS);
	assign lrow     = stc_pkg::row_t'(32'(cell_index[7:5]));
	assign rsum     = stc_pkg::rowx_t'(lrow) + stc_pkg::rowx_t'(top_q);
	assign rrow     = (rsum >= stc_pkg::rowx_t'(stc_pkg::PANE_ROWS))
	                  ? stc_pkg::row_t'(rsum - stc_pkg::rowx_t'(stc_pkg::PANE_ROWS))
	                  : stc_pkg::row_t'(rsum);
	assign rd_addr  = {rrow, cell_index[4:0]};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {bot_row, col_q};
		wr_data = stc_pkg::CH_SPACE;
		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = (clr_q == stc_pkg::addr_t'(stc_pkg::BOTTOM_BASE))
				          ? stc_pkg::CH_CURSOR : stc_pkg::CH_SPACE;
			end
			S_BLANK, S_NL: wr_en = 1'b1;
			S_STORE: begin
				wr_en   = 1'b1;
				wr_data = byte_q;
			end
			S_MARK: begin
				wr_en   = 1'b1;
				wr_data = stc_pkg::CH_CURSOR;
			end
			S_SCROLL: begin
				// old top row becomes the new bottom row
				wr_en   = 1'b1;
				wr_addr = {top_q, col_q};
				wr_data = (col_q == '0) ? stc_pkg::CH_CURSOR : stc_pkg::CH_SPACE;
			end
			default: wr_en = 1'b0;
		endcase
	end

	assign after_step = (dec_q && !last_q) ? S_DWAIT : S_DONE;

	assign dig_cmd.start = accept && (func == stc_pkg::FUNC_DEC);
	assign dig_cmd.take  = (state_q == S_DWAIT) && dig_out.ready;
	assign dig_cmd.value = value;

	stc_ram #(
		.WIDTH(8),
		.DEPTH(stc_pkg::PANE_CELLS)
	) u_pane (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	stc_digit_unit u_digits (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (dig_cmd),
		.dout  (dig_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			col_q        <= '0;
			top_q        <= '0;
			clr_q        <= '0;
			byte_q       <= '0;
			dec_q        <= 1'b0;
			last_q       <= 1'b0;
			rd_ok_q      <= 1'b0;
			res_q        <= '0;
			out_valid_q  <= 1'b0;
			read_data_q  <= '0;
			cursor_col_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + stc_pkg::addr_t'(1);
					if (clr_q == stc_pkg::addr_t'(stc_pkg::PANE_CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						dec_q  <= 1'b0;
						last_q <= 1'b0;
						res_q  <= '0;
						unique case (func)
							stc_pkg::FUNC_READ: begin
								rd_ok_q <= in_range;
								state_q <= S_READ;
							end
							stc_pkg::FUNC_RAW: begin
								byte_q  <= ch;
								state_q <= S_STORE;
							end
							stc_pkg::FUNC_DEC: begin
								dec_q   <= 1'b1;
								state_q <= S_DWAIT;
							end
							default: begin
								byte_q <= mapped;
								if (ch == stc_pkg::CH_NEWLINE) begin
									state_q <= S_NL;
								end else if (ch < 8'd32) begin
									state_q <= S_BLANK;
								end else begin
									state_q <= S_STORE;
								end
							end
						endcase
					end
				end
				S_READ: begin
					res_q   <= rd_ok_q ? rd_data : 8'd0;
					state_q <= S_DONE;
				end
				S_BLANK: state_q <= S_DONE;
				S_STORE: begin
					col_q <= col_q + stc_pkg::col_t'(1);
					if (col_q == stc_pkg::col_t'(stc_pkg::ROW_CELLS - 1)) begin
						state_q <= S_SCROLL;
					end else begin
						state_q <= S_MARK;
					end
				end
				S_MARK: state_q <= after_step;
				S_NL: begin
					col_q <= col_q + stc_pkg::col_t'(1);
					if (col_q == stc_pkg::col_t'(stc_pkg::ROW_CELLS - 1)) begin
						state_q <= S_SCROLL;
					end
				end
				S_SCROLL: begin
					col_q <= col_q + stc_pkg::col_t'(1);
					if (col_q == stc_pkg::col_t'(stc_pkg::ROW_CELLS - 1)) begin
						top_q   <= top_next;
						state_q <= after_step;
					end
				end
				S_DWAIT: begin
					if (dig_out.ready) begin
						byte_q  <= stc_pkg::CH_ZERO + 8'(dig_out.digit);
						last_q  <= dig_out.last;
						state_q <= S_STORE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						read_data_q  <= res_q;
						cursor_col_q <= col_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign cursor_col = cursor_col_q;

	a_top_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(top_q) < stc_pkg::PANE_ROWS)
		else $error("row base out of range");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE || state_q == S_READ) |-> !wr_en)
		else $error("pane write outside an update step");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result without finished item");

	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL && col_q == stc_pkg::col_t'(stc_pkg::ROW_CELLS - 1))
		|=> (col_q == '0 && top_q != $past(top_q)))
		else $error("scroll did not rotate rows");

	a_read_nonread_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !dec_q && $past(state_q) != S_READ
		 && $past(state_q) != S_DONE) |-> res_q == 8'd0)
		else $error("read data on a write item");

endmodule
